// File: sv/sbda_pkg.sv
package sbda_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned Digits = 10;
  localparam int unsigned BcdW   = 4 * Digits;
  localparam int unsigned CntW   = $clog2(DataW + 1);
  localparam int unsigned NdW    = $clog2(Digits + 1);
  localparam int unsigned CharW  = 8;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [3:0]       DigitFive = 4'd5;
  localparam logic [3:0]       DigitAdj  = 4'd3;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  // add-3 correction on every BCD digit of five or more
  function automatic logic [BcdW-1:0] bcd_adjust(logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int i = 0; i < Digits; i++) begin
      if (b[4*i +: 4] >= DigitFive) begin
        r[4*i +: 4] = b[4*i +: 4] + DigitAdj;
      end
    end
    return r;
  endfunction

endpackage

// File: sv/sbda_ifs.sv
interface sbda_in_if;
  import sbda_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
  import sbda_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// File: sv/sbda_dabble.sv
module sbda_dabble (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sbda_pkg::DataW-1:0] mag_i,
  output logic                      done_o,
  output logic [sbda_pkg::BcdW-1:0]  bcd_o
);
  import sbda_pkg::*;

  logic [DataW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [BcdW-1:0]  corr;

  always_comb begin
    corr   = bcd_adjust(bcd_q);
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {corr[BcdW-2:0], bin_q[DataW-1]};
      bin_d = {bin_q[DataW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

`ifndef NO_ASSERTIONS
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("shift count ran out while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("conversion not started");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still shifting");
`endif

endmodule

// File: sv/signed_binary_to_decimal_ascii_unit.sv
// From the accepted transaction to the first character the magnitude passes through
// 32 shift-add-3 steps in the BCD unit, then leading-zero skipping.
// Characters follow at one per cycle while the sink is ready.
// Ready only when idle: no new value is taken before the last character goes out.
// Asynchronous active-low reset returns the sequencer to idle with no output.
module signed_binary_to_decimal_ascii_unit (
  input logic       clk_i,
  input logic       rst_ni,
  sbda_in_if.sink   in_i,
  sbda_out_if.source out_o
);
  import sbda_pkg::*;

  state_e           state_q, state_d;
  logic [BcdW-1:0]  dig_q, dig_d;
  logic [NdW-1:0]   nd_q, nd_d;
  logic             neg_q, neg_d;
  logic             start;
  logic             conv_done;
  logic [BcdW-1:0]  conv_bcd;
  logic [DataW-1:0] raw;
  logic [DataW-1:0] mag;
  logic [3:0]       top_dig;

  assign raw     = in_i.value;
  assign mag     = raw[DataW-1] ? (DataW'(0) - raw) : raw;
  assign top_dig = dig_q[BcdW-1 -: 4];

  sbda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  always_comb begin
    state_d         = state_q;
    dig_d           = dig_q;
    nd_d            = nd_q;
    neg_d           = neg_q;
    start           = 1'b0;
    in_i.ready      = 1'b0;
    out_o.valid     = 1'b0;
    out_o.char_code = CharZero + {4'b0000, top_dig};
    out_o.last      = 1'b0;
    case (state_q)
      StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          neg_d   = raw[DataW-1];
          start   = 1'b1;
          state_d = StConv;
        end
      end
      StConv: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          nd_d    = NdW'(Digits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_dig == 4'd0 && nd_q != NdW'(1)) begin
          dig_d = {dig_q[BcdW-5:0], 4'd0};
          nd_d  = nd_q - 1'b1;
        end else begin
          state_d = neg_q ? StSign : StDigit;
        end
      end
      StSign: begin
        out_o.valid     = 1'b1;
        out_o.char_code = CharMinus;
        if (out_o.ready) begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        out_o.valid = 1'b1;
        out_o.last  = (nd_q == NdW'(1));
        if (out_o.ready) begin
          dig_d = {dig_q[BcdW-5:0], 4'd0};
          nd_d  = nd_q - 1'b1;
          if (nd_q == NdW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    neg_q <= neg_d;
  end

`ifndef NO_ASSERTIONS
  a_out_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while characters pending");
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) |-> (nd_q != '0 && nd_q <= NdW'(Digits)))
    else $error("digit count out of range");
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == StConv))
    else $error("conversion not entered after transaction");
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> (state_q == StConv))
    else $error("conversion finished outside conversion state");
`endif

endmodule
